// ===== design/b32c_pkg.sv =====
// ----------------------------------------------------------------------------
// b32c_pkg: shared types and constants of the base32 stream codec
// Holds the alphabet mapping, the record that passes from the front to the
// back part, and the queue status bundle.
// ----------------------------------------------------------------------------
package b32c_pkg;

  localparam int unsigned StoreW = 12;
  localparam int unsigned FillW  = 4;
  localparam int unsigned SymW   = 5;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned MaxRes = 3;

  localparam logic [ByteW-1:0] ChA = 8'h41;
  localparam logic [ByteW-1:0] ChZ = 8'h5A;
  localparam logic [ByteW-1:0] Ch1 = 8'h31;
  localparam logic [ByteW-1:0] Ch6 = 8'h36;
  localparam logic [SymW-1:0]  NumLetters = 5'd26;

  localparam logic DirEncode = 1'b0;
  localparam logic DirDecode = 1'b1;

  typedef logic [1:0] cnt_t;

  // One accepted item's worth of results, one to three entries.
  typedef struct packed {
    cnt_t                         cnt;
    logic [MaxRes-1:0][ByteW-1:0] val;
    logic                         last;
    logic                         empty;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [ByteW-1:0] sym_char(input logic [SymW-1:0] idx);
    logic [ByteW-1:0] ch;
    if (idx < NumLetters) begin
      ch = ChA + {3'b000, idx};
    end else begin
      ch = Ch1 + {3'b000, idx - NumLetters};
    end
    return ch;
  endfunction

  // Returns {valid, code}; valid is low for values outside the alphabet.
  function automatic logic [SymW:0] sym_code(input logic [ByteW-1:0] ch);
    logic [ByteW-1:0] diff;
    logic [SymW:0]    res;
    res = '0;
    if (ch >= ChA && ch <= ChZ) begin
      diff = ch - ChA;
      res  = {1'b1, diff[SymW-1:0]};
    end else if (ch >= Ch1 && ch <= Ch6) begin
      diff = ch - Ch1;
      res  = {1'b1, diff[SymW-1:0] + NumLetters};
    end
    return res;
  endfunction

endpackage

// ===== design/base32_stream_codec_core.sv =====
// ----------------------------------------------------------------------------
// base32_stream_codec_core: streaming base32 encoder and decoder
// Alphabet A-Z then 1-6, no padding. Direction selects encode or decode.
//
// Usage: bytes or characters enter on the in_valid_i / in_ready_o channel,
// each transaction carrying in_value_i and in_last_i. Results leave on the
// out_valid_o / out_ready_i channel with out_value_o, out_last_o and
// out_empty_o. Writing cfg_we_i with cfg_wdata_i sets the direction and
// clears the bit buffer; write it only while the block is idle.
// The first result of an item passes through the record queue and then the output register.
// The output side moves one result per cycle while the receiver is ready
// and the queue holds a record. An item makes up to three results when
// encoding, about 1.6 on average, and at most one when decoding. The front
// part takes an item in every cycle while the record queue has room.
// Reset selects encode mode and empties the buffer, the queue and the
// output register. When the receiver stalls, the output register holds,
// the queue fills, and in_ready_o drops once the queue is full.
// ----------------------------------------------------------------------------
module base32_stream_codec_core import b32c_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] in_value_i,
  input  logic             in_last_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] out_value_o,
  output logic             out_last_o,
  output logic             out_empty_o
);

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic            push, pop;
  rec_t            push_rec, head;
  q_stat_t         q_stat;
  logic [CntW-1:0] q_count;
  logic [FillW-1:0] fill;

  b32c_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_value_i (in_value_i),
    .in_last_i  (in_last_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .rec_o      (push_rec),
    .fill_o     (fill)
  );

  b32c_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_rec_i(push_rec),
    .pop_i     (pop),
    .head_o    (head),
    .stat_o    (q_stat),
    .count_o   (q_count)
  );

  b32c_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .q_stat_i   (q_stat),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_value_o(out_value_o),
    .out_last_o (out_last_o),
    .out_empty_o(out_empty_o)
  );

  a_marker_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_empty_o |-> out_last_o && out_value_o == '0)
    else $error("End marker without last flag or with data.");

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= CntW'(QueueDepth))
    else $error("Record queue count exceeds its depth.");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill < 4'd8)
    else $error("Bit buffer holds a full byte after an item.");

  a_record_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> push_rec.cnt != 2'd0)
    else $error("Record pushed with no results.");

endmodule

// ===== design/b32c_front.sv =====
// ----------------------------------------------------------------------------
// b32c_front: input side of the base32 stream codec
// Accepts items, updates the bit buffer and builds a result record for
// the queue for each item that makes results or carries the last flag.
// ----------------------------------------------------------------------------
module b32c_front import b32c_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] in_value_i,
  input  logic             in_last_i,
  input  q_stat_t          q_stat_i,
  output logic             push_o,
  output rec_t             rec_o,
  output logic [FillW-1:0] fill_o
);

  logic              dir_q;
  logic [StoreW-1:0] store_q, store_d;
  logic [FillW-1:0]  fill_q, fill_d;

  logic [StoreW-1:0] es, ds;
  logic [FillW-1:0]  ef, ef2, df;
  logic [StoreW-1:0] sh0, sh1, shf, shd;
  logic [SymW:0]     code;
  logic              accept;
  cnt_t              n;
  rec_t              rec;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    rec     = '0;
    n       = '0;
    store_d = store_q;
    fill_d  = fill_q;
    es      = {store_q[3:0], in_value_i};
    ef      = fill_q + 4'd8;
    sh0     = es >> (ef - 4'd5);
    sh1     = es >> (ef - 4'd10);
    ef2     = (ef >= 4'd10) ? ef - 4'd10 : ef - 4'd5;
    shf     = es << (4'd5 - ef2);
    code    = sym_code(in_value_i);
    ds      = {store_q[6:0], code[SymW-1:0]};
    df      = fill_q + 4'd5;
    shd     = ds >> (df - 4'd8);
    if (dir_q == DirEncode) begin
      rec.val[0] = sym_char(sh0[SymW-1:0]);
      n          = 2'd1;
      if (ef >= 4'd10) begin
        rec.val[1] = sym_char(sh1[SymW-1:0]);
        n          = 2'd2;
        if (in_last_i && ef2 != '0) begin
          rec.val[2] = sym_char(shf[SymW-1:0]);
          n          = 2'd3;
        end
      end else if (in_last_i && ef2 != '0) begin
        rec.val[1] = sym_char(shf[SymW-1:0]);
        n          = 2'd2;
      end
      store_d = es;
      fill_d  = ef2;
    end else if (code[SymW]) begin
      store_d = ds;
      fill_d  = df;
      if (df >= 4'd8) begin
        rec.val[0] = shd[ByteW-1:0];
        n          = 2'd1;
        fill_d     = df - 4'd8;
      end
    end
    if (in_last_i) begin
      if (n == 2'd0) begin
        rec.empty = 1'b1;
        n         = 2'd1;
      end
      rec.last = 1'b1;
      store_d  = '0;
      fill_d   = '0;
    end
    rec.cnt = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q   <= DirEncode;
      store_q <= '0;
      fill_q  <= '0;
    end else if (cfg_we_i) begin
      dir_q   <= cfg_wdata_i;
      store_q <= '0;
      fill_q  <= '0;
    end else if (accept) begin
      store_q <= store_d;
      fill_q  <= fill_d;
    end
  end

  assign push_o = accept && (n != 2'd0);
  assign rec_o  = rec;
  assign fill_o = fill_q;

endmodule

// ===== design/b32c_queue.sv =====
// ----------------------------------------------------------------------------
// b32c_queue: record queue of the base32 stream codec
// A short first-in first-out buffer that decouples the front and back parts.
// ----------------------------------------------------------------------------
module b32c_queue import b32c_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  rec_t                       push_rec_i,
  input  logic                       pop_i,
  output rec_t                       head_o,
  output q_stat_t                    stat_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rec_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign do_pop  = pop_i && (cnt_q != '0);
  assign do_push = push_i && (cnt_q != CntW'(Depth));

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_rec_i;
    end
  end

  assign head_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign count_o      = cnt_q;

endmodule

// ===== design/b32c_back.sv =====
// ----------------------------------------------------------------------------
// b32c_back: output side of the base32 stream codec
// Walks the head record one result at a time into the output register.
// ----------------------------------------------------------------------------
module b32c_back import b32c_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rec_t             head_i,
  input  q_stat_t          q_stat_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] out_value_o,
  output logic             out_last_o,
  output logic             out_empty_o
);

  logic             valid_q;
  logic [ByteW-1:0] value_q;
  logic             last_q, empty_q;
  cnt_t             idx_q, idx_d;
  logic             load, fin;
  logic [ByteW-1:0] sel;

  assign load = (!valid_q || out_ready_i) && !q_stat_i.empty;
  assign fin  = (idx_q == head_i.cnt - 2'd1);

  always_comb begin
    case (idx_q)
      2'd0:    sel = head_i.val[0];
      2'd1:    sel = head_i.val[1];
      2'd2:    sel = head_i.val[2];
      default: sel = '0;
    endcase
    idx_d = idx_q;
    if (load) begin
      idx_d = fin ? '0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      value_q <= sel;
      last_q  <= head_i.last && fin;
      empty_q <= head_i.empty;
    end
  end

  assign pop_o       = load && fin;
  assign out_valid_o = valid_q;
  assign out_value_o = value_q;
  assign out_last_o  = last_q;
  assign out_empty_o = empty_q;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the base32 stream codec core
// Drives bytes and characters in both directions and predicts every result
// in a scoreboard that keeps its own copy of the bit buffer. Both channels
// idle at random. Each accepted result is compared with the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module tb;
  import b32c_pkg::*;

  typedef struct packed {
    logic [ByteW-1:0] value;
    logic             last;
    logic             empty;
  } out_beat_t;

  localparam string       Alphabet    = "ABCDEFGHIJKLMNOPQRSTUVWXYZ123456";
  localparam int unsigned BufMask     = 12'hFFF;
  localparam int unsigned BufBits     = 12;
  localparam int          DrainCycles = 12;
  localparam int          MaxReports  = 20;
  localparam int          RandomItems = 130;

  class codec_scoreboard;
    logic        dir;
    int unsigned acc;
    int unsigned fill;
    out_beat_t   awaited[$];
    int          errors;
    int          items;
    int          results;

    function new();
      dir     = DirEncode;
      acc     = 0;
      fill    = 0;
      errors  = 0;
      items   = 0;
      results = 0;
    endfunction

    function void set_dir(logic d);
      dir  = d;
      acc  = 0;
      fill = 0;
    endfunction

    function int awaiting();
      return awaited.size();
    endfunction

    function void note_item(logic [ByteW-1:0] v, logic l);
      out_beat_t   outs[$];
      out_beat_t   beat;
      int          code;
      int unsigned idx;
      items++;
      beat = '0;
      if (dir == DirEncode) begin
        acc  = ((acc << 8) | v) & BufMask;
        fill = (fill + 8 > BufBits) ? BufBits : fill + 8;
        while (fill >= SymW && outs.size() < MaxRes) begin
          idx = (acc >> (fill - SymW)) & 31;
          beat.value = Alphabet[idx];
          outs.push_back(beat);
          fill -= SymW;
        end
        if (l && fill > 0 && outs.size() < MaxRes) begin
          idx = (acc << (SymW - fill)) & 31;
          beat.value = Alphabet[idx];
          outs.push_back(beat);
        end
      end else begin
        code = -1;
        for (int i = 0; i < 32; i++) begin
          if (Alphabet[i] == v) begin
            code = i;
          end
        end
        if (code >= 0) begin
          acc  = ((acc << SymW) | code) & BufMask;
          fill = (fill + SymW > BufBits) ? BufBits : fill + SymW;
          if (fill >= ByteW) begin
            beat.value = 8'((acc >> (fill - ByteW)) & 8'hFF);
            outs.push_back(beat);
            fill -= ByteW;
          end
        end
      end
      acc &= BufMask;
      if (l) begin
        if (outs.size() == 0) begin
          beat       = '0;
          beat.last  = 1'b1;
          beat.empty = 1'b1;
          outs.push_back(beat);
        end else begin
          outs[outs.size()-1].last = 1'b1;
        end
        acc  = 0;
        fill = 0;
      end
      foreach (outs[i]) begin
        awaited.push_back(outs[i]);
      end
    endfunction

    function void check_result(logic [ByteW-1:0] v, logic l, logic e);
      out_beat_t want;
      results++;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("%0t: result with nothing expected: value %h last %b empty %b",
                   $time, v, l, e);
        end
        return;
      end
      want = awaited.pop_front();
      if (want.value !== v) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("%0t: out_value expected %h actual %h", $time, want.value, v);
        end
      end
      if (want.last !== l) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("%0t: out_last expected %b actual %b", $time, want.last, l);
        end
      end
      if (want.empty !== e) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("%0t: out_empty expected %b actual %b", $time, want.empty, e);
        end
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic             cfg_wdata_i;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [ByteW-1:0] in_value_i;
  logic             in_last_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [ByteW-1:0] out_value_o;
  logic             out_last_o;
  logic             out_empty_o;

  codec_scoreboard sb = new();
  int              sent;
  int              dir_writes;
  bit              in_gaps;
  bit              out_gaps;

  base32_stream_codec_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_value_i  (in_value_i),
    .in_last_i   (in_last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_value_o (out_value_o),
    .out_last_o  (out_last_o),
    .out_empty_o (out_empty_o)
  );

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic write_dir(input logic d);
    cfg_wdata_i <= d;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_dir(d);
    dir_writes++;
  endtask

  task automatic offer_item(input logic [ByteW-1:0] v, input logic l);
    int gap;
    if (sent % 16 == 0) begin
      in_gaps = ($urandom_range(0, 2) != 0);
    end
    gap = in_gaps ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_value_i <= v;
    in_last_i  <= l;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_item(v, l);
    sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.awaiting() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin : sink
    int stall;
    int taken;
    taken       = 0;
    out_ready_i = 1'b0;
    forever begin
      if (taken % 16 == 0) begin
        out_gaps = ($urandom_range(0, 2) != 0);
      end
      stall = out_gaps ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      sb.check_result(out_value_o, out_last_o, out_empty_o);
      taken++;
    end
  end

  initial begin : stimulus
    int               phase;
    int               rnd_items;
    int               phase_items;
    int               count;
    int               len;
    logic             d;
    logic             noise;
    logic [ByteW-1:0] v;
    sent        = 0;
    dir_writes  = 0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b0;
    in_valid_i  = 1'b0;
    in_value_i  = '0;
    in_last_i   = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_dir(DirEncode);
    offer_item(8'h00, 1'b1);
    offer_item(8'hFF, 1'b1);
    offer_item(8'h80, 1'b0);
    offer_item(8'h01, 1'b0);
    offer_item(8'h55, 1'b0);
    offer_item(8'hAA, 1'b0);
    offer_item(8'h7F, 1'b1);
    settle();

    write_dir(DirDecode);
    offer_item("A", 1'b0);
    offer_item("6", 1'b0);
    offer_item("@", 1'b0);
    offer_item("[", 1'b0);
    offer_item("0", 1'b0);
    offer_item("7", 1'b0);
    offer_item(8'h00, 1'b0);
    offer_item(8'hFF, 1'b0);
    offer_item("Z", 1'b0);
    offer_item("1", 1'b0);
    offer_item("a", 1'b1);
    offer_item("Q", 1'b1);
    settle();

    write_dir(DirDecode);
    phase     = 0;
    rnd_items = 0;
    while (rnd_items < RandomItems) begin
      d = (phase < 2) ? phase[0] : 1'($urandom_range(0, 1));
      write_dir(d);
      phase_items = $urandom_range(15, 35);
      count       = 0;
      while (count < phase_items) begin
        len = $urandom_range(1, 10);
        for (int j = 0; j < len; j++) begin
          noise = (d == DirDecode) && ($urandom_range(0, 6) == 0);
          if (d == DirEncode || noise) begin
            v = 8'($urandom_range(0, 255));
          end else begin
            v = Alphabet[$urandom_range(0, 31)];
          end
          offer_item(v, (j == len - 1) && ($urandom_range(0, 7) != 0));
          count++;
          if (!noise) begin
            rnd_items++;
          end
        end
      end
      settle();
      phase++;
    end

    $display("Covered %0d input transactions and %0d result transactions", sb.items,
             sb.results);
    $display("over %0d direction writes in both encode and decode mode.", dir_writes);
    if (sb.errors == 0 && sb.awaiting() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
design/b32c_pkg.sv
design/b32c_front.sv
design/b32c_queue.sv
design/b32c_back.sv
design/base32_stream_codec_core.sv
tb/tb.sv
